[hw/rtl/msp_v1_frame_parser_core_macros.svh]
// Assertion macros for the MSP v1 frame parser core.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef MSP_V1_FRAME_PARSER_CORE_MACROS_SVH
`define MSP_V1_FRAME_PARSER_CORE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define MSP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/msp_pkg.sv]
// Shared types and constants for the MSP v1 frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msp_pkg;

    localparam int DEF_BUF_DEPTH = 64;
    localparam int BYTE_W        = 8;
    localparam int M_TDATA_W     = 32;
    localparam int M_TUSER_W     = 2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DOLLAR,
        F_GOT_M,
        F_SIZE,
        F_CMD,
        F_PAYLOAD,
        F_CHECK
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_OUT
    } back_state_t;

    // Descriptor of one checked frame, waiting to be emitted.
    typedef struct packed {
        logic        is_reply;
        logic [7:0]  cmd;
        logic [7:0]  size;
        logic        bank;
    } desc_t;

    // Payload store write request from the parser.
    typedef struct packed {
        logic        en;
        logic        bank;
        logic [7:0]  idx;
        logic [7:0]  data;
    } wr_t;

endpackage

[hw/rtl/msp_front.sv]
// Parser front end: walks the MSP v1 frame, checks the XOR sum,
// writes payload words into the store and pushes frame descriptors. Uses msp_pkg.
`timescale 1ns / 1ps

module msp_front
    import msp_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] rx_byte
    input  logic       q_full,
    output logic       push,
    output desc_t      push_desc,
    output wr_t        wr
);

    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    front_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       size_reg, size_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic             reply_reg, reply_next;
    logic             bank_reg, bank_next;
    logic             acc;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       c;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        if (acc) begin
            case (state_reg)
                F_IDLE:    state_next = (c == CH_DOLLAR) ? F_DOLLAR : F_IDLE;
                F_DOLLAR:  state_next = (c == CH_M) ? F_GOT_M : F_IDLE;
                F_GOT_M:   state_next = (c == CH_LT || c == CH_GT) ? F_SIZE : F_IDLE;
                F_SIZE:    state_next = F_CMD;
                F_CMD: begin
                    if (size_reg > 8'(BUF_DEPTH)) begin
                        state_next = F_IDLE;
                    end else if (size_reg == 8'd0) begin
                        state_next = F_CHECK;
                    end else begin
                        state_next = F_PAYLOAD;
                    end
                end
                F_PAYLOAD: state_next = (8'(cnt_inc) >= size_reg) ? F_CHECK : F_PAYLOAD;
                F_CHECK:   state_next = F_IDLE;
                default:   state_next = (c == CH_DOLLAR) ? F_DOLLAR : F_IDLE;
            endcase
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        size_next  = size_reg;
        cmd_next   = cmd_reg;
        reply_next = reply_reg;
        bank_next  = bank_reg;
        push       = 1'b0;
        wr.en      = 1'b0;
        wr.bank    = bank_reg;
        wr.idx     = 8'(cnt_reg);
        wr.data    = c;
        if (acc) begin
            case (state_reg)
                F_DOLLAR: begin
                    cnt_next = '0;
                    xor_next = 8'd0;
                end
                F_GOT_M: begin
                    if (c == CH_LT) begin
                        reply_next = 1'b0;
                    end else if (c == CH_GT) begin
                        reply_next = 1'b1;
                    end
                end
                F_SIZE: begin
                    xor_next  = xor_reg ^ c;
                    size_next = c;
                end
                F_CMD: begin
                    xor_next = xor_reg ^ c;
                    cmd_next = c;
                    cnt_next = '0;
                end
                F_PAYLOAD: begin
                    xor_next = xor_reg ^ c;
                    wr.en    = 1'b1;
                    cnt_next = cnt_inc;
                end
                F_CHECK: begin
                    // A good frame hands its bank to the back end; the next
                    // frame fills the other one.
                    if (xor_reg == c) begin
                        push      = 1'b1;
                        bank_next = !bank_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign push_desc.is_reply = reply_reg;
    assign push_desc.cmd      = cmd_reg;
    assign push_desc.size     = size_reg;
    assign push_desc.bank     = bank_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            xor_reg   <= 8'd0;
            size_reg  <= 8'd0;
            cmd_reg   <= 8'd0;
            reply_reg <= 1'b0;
            bank_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            size_reg  <= size_next;
            cmd_reg   <= cmd_next;
            reply_reg <= reply_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

[hw/rtl/msp_queue.sv]
// Two-entry descriptor queue between parser and emitter.
// One entry per payload bank. Uses msp_pkg.
`timescale 1ns / 1ps

module msp_queue
    import msp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output logic  full,
    output logic  valid,
    output desc_t head
);

    desc_t       ent_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = ent_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

[hw/rtl/msp_back.sv]
// Emitter back end: holds the two-bank payload store and plays each queued
// frame out as one result word per payload byte, or one word for an empty frame. Uses msp_pkg.
`timescale 1ns / 1ps

module msp_back
    import msp_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wr_t                   wr,
    input  logic                  q_valid,
    input  desc_t                 head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // command_id, payload_length, payload_index,
                                            // payload_byte, zero pad (from bit 0 up)
    output logic [M_TUSER_W-1:0]  m_tuser,  // is_reply, has_payload (from bit 0 up)
    output logic                  m_tlast
);

    localparam int IDX_W  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int MEM_SZ = 2 << IDX_W;

    logic [7:0]       mem [MEM_SZ];
    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       rdata_reg;
    logic             rd_en;
    logic             has;
    logic             is_last;
    logic [7:0]       idx8;
    logic [7:0]       byte_out;

    assign idx8     = 8'(idx_reg);
    assign has      = (head.size != 8'd0);
    assign is_last  = !has || ((idx8 + 8'd1) == head.size);
    assign byte_out = has ? rdata_reg : 8'd0;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[{wr.bank, wr.idx[IDX_W-1:0]}] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[{head.bank, idx_reg}];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    state_next = has ? B_READ : B_OUT;
                end
            end
            B_READ: state_next = B_OUT;
            B_OUT: begin
                if (m_tready) begin
                    state_next = is_last ? B_IDLE : B_READ;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        rd_en    = 1'b0;
        pop      = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            B_IDLE: idx_next = '0;
            B_READ: rd_en = 1'b1;
            B_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (is_last) begin
                        pop = 1'b1;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tdata = {3'b000, byte_out, idx8[5:0], head.size[6:0], head.cmd};
    assign m_tuser = {has, head.is_reply};
    assign m_tlast = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[hw/rtl/msp_v1_frame_parser_core.sv]
// Channel   | Dir | Word
// s_ (rx)   | in  | s_tdata[7:0] rx_byte
// m_ (out)  | out | m_tdata command_id/payload_length/payload_index/payload_byte,
//           |     | m_tuser is_reply/has_payload, m_tlast last
// Received bytes are taken one per cycle while the descriptor queue has room.
// Each result word takes a store read (B_READ), then output (B_OUT), held until
// m_tready; an empty frame's single word skips the read; each frame starts from B_IDLE.
// Two payload banks let a new frame arrive while the previous one drains.
// Reset clears all control state at once; no clearing pass is needed.
// Top level: parser front end, descriptor queue and emitter. Uses msp_pkg
// and the assertion macros header.
`timescale 1ns / 1ps
`include "msp_v1_frame_parser_core_macros.svh"

module msp_v1_frame_parser_core
    import msp_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // command_id, payload_length, payload_index,
                                            // payload_byte, zero pad (from bit 0 up)
    output logic [M_TUSER_W-1:0]  m_tuser,  // is_reply, has_payload (from bit 0 up)
    output logic                  m_tlast
);

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    desc_t push_desc;
    desc_t head;
    wr_t   wr;

    msp_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .wr        (wr)
    );

    msp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (head)
    );

    msp_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A frame is only queued when a bank is free.
    `MSP_ASSERT_ALWAYS(a_push_room, !(push && q_full), "descriptor pushed into full queue")
    // Results only come from a queued frame.
    `MSP_ASSERT_ALWAYS(a_out_has_frame, !m_tvalid || q_valid, "result word without frame")
    // The queue is released exactly when the last word of a frame leaves.
    `MSP_ASSERT_ALWAYS(a_pop_last, pop == (m_tvalid && m_tready && m_tlast),
        "queue pop not tied to last word")
    // Writes never land in the bank that is being played out.
    `MSP_ASSERT_ALWAYS(a_bank_split, !(wr.en && q_valid && m_tvalid && wr.bank == head.bank),
        "payload write into draining bank")

endmodule
